>>> hw/rtl/trial_division_prime_test_top_macros.svh
// ----------------------------------------------------------------------------
// Trial division prime test: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define TDP_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define TDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tdp_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test: package
// Shared constants and the control and status types of the serial divider.
// ----------------------------------------------------------------------------
package tdp_pkg;

  localparam int VALUE_BITS_DEF = 16;

  // Trial divisors start here.
  localparam int FIRST_DIVISOR = 2;

  // Smallest prime; anything below it is not prime.
  localparam int MIN_PRIME = 2;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hw/rtl/tdp_divider.sv
// ----------------------------------------------------------------------------
// Trial division prime test: serial remainder unit
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module tdp_divider #(
  parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tdp_pkg::div_ctrl_t                  ctrl,
  input  logic [VALUE_BITS-1:0]               dividend,
  input  logic [(VALUE_BITS+1)/2:0]           divisor,
  output tdp_pkg::div_stat_t                  stat,
  output logic [(VALUE_BITS+1)/2:0]           remainder
);

  localparam int DW    = (VALUE_BITS + 1) / 2 + 1;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [CNT_W-1:0]      cnt;
  logic [VALUE_BITS-1:0] shreg;
  logic [DW-1:0]         rem;
  logic [DW-1:0]         rem_next;
  logic                  done;
  logic [DW:0]           trial;

  always_comb begin
    trial = {rem, shreg[VALUE_BITS-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = DW'(trial - {1'b0, divisor});
    end else begin
      rem_next = DW'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        cnt   <= CNT_W'(VALUE_BITS);
        shreg <= dividend;
        rem   <= '0;
      end else if (cnt != '0) begin
        rem   <= rem_next;
        shreg <= shreg << 1;
        cnt   <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = done;
  assign remainder = rem;

endmodule

>>> hw/rtl/trial_division_prime_test_top.sv
// ----------------------------------------------------------------------------
// Trial division prime test: top level
// Sequencer that drives trial divisors through a single serial divider.
// ----------------------------------------------------------------------------
// One value is tested at a time. Divisors d = 2, 3, ... are tried while d*d
// does not exceed the value; the first zero remainder ends the test as not
// prime, and 0 and 1 are reported as not prime. Each trial runs through the
// serial divider, one dividend bit per cycle. A test makes k trials, with k
// at most floor(sqrt(value)) - 1. The square d*d is tracked by an adder, not
// a multiplier. A finished result waits in an output register, and the next
// value can be transferred in meanwhile.
module trial_division_prime_test_top #(
  parameter int VALUE_BITS = tdp_pkg::VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  is_prime
);

`include "trial_division_prime_test_top_macros.svh"

  localparam int DW   = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_W = 2 * DW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_RESULT
  } state_t;

  state_t             state;
  logic [VALUE_BITS-1:0] v;
  logic [DW-1:0]      d;
  logic [SQ_W-1:0]    sq;
  logic               prime_r;
  tdp_pkg::div_ctrl_t div_ctrl;
  tdp_pkg::div_stat_t div_stat;
  logic [DW-1:0]      rem;
  logic               div_active;

  tdp_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (div_ctrl),
    .dividend (v),
    .divisor  (d),
    .stat     (div_stat),
    .remainder(rem)
  );

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      div_ctrl.start <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            v     <= value;
            d     <= DW'(tdp_pkg::FIRST_DIVISOR);
            sq    <= SQ_W'(tdp_pkg::FIRST_DIVISOR * tdp_pkg::FIRST_DIVISOR);
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (v < VALUE_BITS'(tdp_pkg::MIN_PRIME)) begin
            prime_r <= 1'b0;
            state   <= ST_RESULT;
          end else if (sq > SQ_W'(v)) begin
            prime_r <= 1'b1;
            state   <= ST_RESULT;
          end else begin
            div_ctrl.start <= 1'b1;
            state          <= ST_DIV;
          end
        end
        ST_DIV: begin
          div_ctrl.start <= 1'b0;
          if (div_stat.done) begin
            if (rem == '0) begin
              prime_r <= 1'b0;
              state   <= ST_RESULT;
            end else begin
              // (d + 1)^2 = d^2 + 2d + 1
              d     <= d + DW'(1);
              sq    <= sq + SQ_W'({d, 1'b0}) + SQ_W'(1);
              state <= ST_CHECK;
            end
          end
        end
        ST_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            is_prime  <= prime_r;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign div_active = div_ctrl.start || div_stat.busy || div_stat.done;

  `TDP_ASSERT(a_ready_not_dividing, !(in_ready && div_stat.busy), "ready while dividing")
  `TDP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after transfer")
  `TDP_ASSERT(a_div_running, state != ST_DIV || div_active, "divider idle during trial")
  `TDP_ASSERT(a_square_tracks, state != ST_CHECK || sq == SQ_W'(d) * SQ_W'(d), "square mismatch")

endmodule
